FILE: hw/rtl/tfd_pkg.sv
// ----------------------------------------------------------------------------
// tfd_pkg: shared types and constants for the tagged frame deframer
// Result record, result and error codes, frame kinds and the tag text table.
// ----------------------------------------------------------------------------
package tfd_pkg;

  // Default counter width for payload bytes and register reset value
  localparam int          LEN_BITS_DEF    = 16;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'hFFFF;

  // Result type carried in tuser
  typedef enum logic [1:0] {
    TYPE_PAYLOAD = 2'd0,
    TYPE_OK      = 2'd1,
    TYPE_ERROR   = 2'd2
  } out_type_t;

  // Frame kinds
  localparam logic [1:0] KIND_STRING = 2'd0;
  localparam logic [1:0] KIND_ARRAY  = 2'd1;
  localparam logic [1:0] KIND_IMAGE  = 2'd2;
  localparam logic [1:0] KIND_USER   = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN_TAG = 3'd1;
  localparam logic [2:0] ERR_BAD_TRAILER = 3'd2;
  localparam logic [2:0] ERR_STR_UNTERM  = 3'd3;
  localparam logic [2:0] ERR_TOO_LONG    = 3'd4;

  // One result word
  typedef struct packed {
    out_type_t   out_type;
    logic [1:0]  frame_kind;
    logic [7:0]  data_byte;
    logic [7:0]  sub_type;
    logic [31:0] time_stamp;
    logic [15:0] payload_len;
    logic [2:0]  error_code;
  } result_t;

  // Tag text, zero terminated; positions past the terminator read zero
  function automatic logic [7:0] tag_char(input logic [1:0] kind, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (kind)
      KIND_STRING: begin
        case (pos)
          3'd0: c = "S";
          3'd1: c = "T";
          3'd2: c = "R";
          3'd3: c = "I";
          3'd4: c = "N";
          3'd5: c = "G";
          default: c = 8'h00;
        endcase
      end
      KIND_ARRAY: begin
        case (pos)
          3'd0: c = "A";
          3'd1: c = "R";
          3'd2: c = "R";
          3'd3: c = "A";
          3'd4: c = "Y";
          default: c = 8'h00;
        endcase
      end
      KIND_IMAGE: begin
        case (pos)
          3'd0: c = "I";
          3'd1: c = "M";
          3'd2: c = "A";
          3'd3: c = "G";
          3'd4: c = "E";
          default: c = 8'h00;
        endcase
      end
      default: begin
        case (pos)
          3'd0: c = "U";
          3'd1: c = "S";
          3'd2: c = "E";
          3'd3: c = "R";
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/tfd_parser.sv
// ----------------------------------------------------------------------------
// tfd_parser: frame state machine
// Walks tag, header, payload and trailer one byte per accepted word and
// produces at most one result per byte.
// ----------------------------------------------------------------------------
module tfd_parser #(
  parameter int LEN_BITS = tfd_pkg::LEN_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_accept,
  input  logic [7:0]        rx_byte,
  input  logic [15:0]       max_payload,
  output logic              res_valid,
  output tfd_pkg::result_t  res
);

  typedef enum logic [7:0] {
    PH_HUNT    = 8'b0000_0001,
    PH_EXPECT  = 8'b0000_0010,
    PH_TAG     = 8'b0000_0100,
    PH_SUB     = 8'b0000_1000,
    PH_STAMP   = 8'b0001_0000,
    PH_LEN     = 8'b0010_0000,
    PH_PAYLOAD = 8'b0100_0000,
    PH_TRAILER = 8'b1000_0000
  } phase_t;

  phase_t                phase_r,  phase_nxt;
  logic [1:0]            kind_r,   kind_nxt;
  logic [2:0]            pos_r,    pos_nxt;
  logic [7:0]            sub_r,    sub_nxt;
  logic [31:0]           stamp_r,  stamp_nxt;
  logic [31:0]           length_r, length_nxt;
  logic [LEN_BITS-1:0]   count_r,  count_nxt;
  logic [7:0]            last_r,   last_nxt;

  logic [7:0]            want;
  logic [31:0]           byte_shifted;
  logic [31:0]           len_full;
  logic [LEN_BITS-1:0]   count_inc;
  logic                  too_long;
  logic                  first_hit;
  logic [1:0]            first_kind;
  tfd_pkg::out_type_t    res_type;
  logic [2:0]            res_err;
  logic [7:0]            res_data;

  // Expected tag character and byte lane placement
  assign want         = tfd_pkg::tag_char(kind_r, pos_r);
  assign byte_shifted = {24'h000000, rx_byte} << {pos_r[1:0], 3'b000};
  assign len_full     = length_r | byte_shifted;
  assign count_inc    = count_r + LEN_BITS'(1);
  assign too_long     = ((len_full >> LEN_BITS) != 32'd0) ||
                        (len_full > {16'h0000, max_payload});

  // Detect a tag's first letter
  always_comb begin
    first_hit  = 1'b1;
    first_kind = tfd_pkg::KIND_STRING;
    if (rx_byte == tfd_pkg::tag_char(tfd_pkg::KIND_STRING, 3'd0)) begin
      first_kind = tfd_pkg::KIND_STRING;
    end else if (rx_byte == tfd_pkg::tag_char(tfd_pkg::KIND_ARRAY, 3'd0)) begin
      first_kind = tfd_pkg::KIND_ARRAY;
    end else if (rx_byte == tfd_pkg::tag_char(tfd_pkg::KIND_IMAGE, 3'd0)) begin
      first_kind = tfd_pkg::KIND_IMAGE;
    end else if (rx_byte == tfd_pkg::tag_char(tfd_pkg::KIND_USER, 3'd0)) begin
      first_kind = tfd_pkg::KIND_USER;
    end else begin
      first_hit = 1'b0;
    end
  end

  // Next state and result for the current byte
  always_comb begin
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    pos_nxt    = pos_r;
    sub_nxt    = sub_r;
    stamp_nxt  = stamp_r;
    length_nxt = length_r;
    count_nxt  = count_r;
    last_nxt   = last_r;
    res_valid  = 1'b0;
    res_type   = tfd_pkg::TYPE_PAYLOAD;
    res_err    = tfd_pkg::ERR_NONE;
    res_data   = 8'h00;
    case (phase_r)
      PH_EXPECT: begin
        sub_nxt    = 8'h00;
        stamp_nxt  = 32'h0;
        length_nxt = 32'h0;
        count_nxt  = '0;
        last_nxt   = 8'h00;
        if (first_hit) begin
          kind_nxt  = first_kind;
          pos_nxt   = 3'd1;
          phase_nxt = PH_TAG;
        end else begin
          // anything but a tag start right after a good frame
          kind_nxt  = tfd_pkg::KIND_STRING;
          phase_nxt = PH_HUNT;
          pos_nxt   = 3'd0;
          res_valid = 1'b1;
          res_type  = tfd_pkg::TYPE_ERROR;
          res_err   = tfd_pkg::ERR_UNKNOWN_TAG;
        end
      end
      PH_TAG: begin
        if (rx_byte != want) begin
          phase_nxt = PH_HUNT;
          pos_nxt   = 3'd0;
          res_valid = 1'b1;
          res_type  = tfd_pkg::TYPE_ERROR;
          res_err   = tfd_pkg::ERR_UNKNOWN_TAG;
        end else if (want != 8'h00) begin
          pos_nxt = pos_r + 3'd1;
        end else if (kind_r == tfd_pkg::KIND_USER) begin
          // header-only frame completes on its terminator
          phase_nxt = PH_EXPECT;
          pos_nxt   = 3'd0;
          res_valid = 1'b1;
          res_type  = tfd_pkg::TYPE_OK;
        end else begin
          phase_nxt = PH_SUB;
          pos_nxt   = 3'd0;
        end
      end
      PH_SUB: begin
        sub_nxt   = rx_byte;
        phase_nxt = PH_STAMP;
        pos_nxt   = 3'd0;
      end
      PH_STAMP: begin
        stamp_nxt = stamp_r | byte_shifted;
        if (pos_r[1:0] == 2'd3) begin
          phase_nxt = PH_LEN;
          pos_nxt   = 3'd0;
        end else begin
          pos_nxt = pos_r + 3'd1;
        end
      end
      PH_LEN: begin
        length_nxt = len_full;
        if (pos_r[1:0] != 2'd3) begin
          pos_nxt = pos_r + 3'd1;
        end else begin
          pos_nxt = 3'd0;
          if (too_long) begin
            phase_nxt = PH_HUNT;
            res_valid = 1'b1;
            res_type  = tfd_pkg::TYPE_ERROR;
            res_err   = tfd_pkg::ERR_TOO_LONG;
          end else if (len_full == 32'h0) begin
            phase_nxt = PH_TRAILER;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        last_nxt  = rx_byte;
        count_nxt = count_inc;
        if (count_inc >= length_r[LEN_BITS-1:0]) begin
          phase_nxt = PH_TRAILER;
          pos_nxt   = 3'd0;
        end
        res_valid = 1'b1;
        res_type  = tfd_pkg::TYPE_PAYLOAD;
        res_data  = rx_byte;
      end
      PH_TRAILER: begin
        if (rx_byte != want) begin
          phase_nxt = PH_HUNT;
          pos_nxt   = 3'd0;
          res_valid = 1'b1;
          res_type  = tfd_pkg::TYPE_ERROR;
          res_err   = tfd_pkg::ERR_BAD_TRAILER;
        end else if (want != 8'h00) begin
          pos_nxt = pos_r + 3'd1;
        end else if (kind_r == tfd_pkg::KIND_STRING &&
                     (length_r == 32'h0 || last_r != 8'h00)) begin
          // string payload must end in a zero byte
          phase_nxt = PH_HUNT;
          pos_nxt   = 3'd0;
          res_valid = 1'b1;
          res_type  = tfd_pkg::TYPE_ERROR;
          res_err   = tfd_pkg::ERR_STR_UNTERM;
        end else begin
          phase_nxt = PH_EXPECT;
          pos_nxt   = 3'd0;
          res_valid = 1'b1;
          res_type  = tfd_pkg::TYPE_OK;
        end
      end
      default: begin
        // hunt: drop bytes until a tag's first letter
        phase_nxt = PH_HUNT;
        if (first_hit) begin
          kind_nxt   = first_kind;
          pos_nxt    = 3'd1;
          sub_nxt    = 8'h00;
          stamp_nxt  = 32'h0;
          length_nxt = 32'h0;
          count_nxt  = '0;
          last_nxt   = 8'h00;
          phase_nxt  = PH_TAG;
        end
      end
    endcase
  end

  // Pack the result from the updated header values
  always_comb begin
    res.out_type    = res_type;
    res.frame_kind  = kind_nxt;
    res.data_byte   = res_data;
    res.sub_type    = sub_nxt;
    res.time_stamp  = stamp_nxt;
    res.payload_len = (|length_nxt[31:16]) ? 16'hFFFF : length_nxt[15:0];
    res.error_code  = res_err;
  end

  // Advance state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      kind_r   <= 2'd0;
      pos_r    <= 3'd0;
      sub_r    <= 8'h00;
      stamp_r  <= 32'h0;
      length_r <= 32'h0;
      count_r  <= '0;
      last_r   <= 8'h00;
    end else if (in_accept) begin
      phase_r  <= phase_nxt;
      kind_r   <= kind_nxt;
      pos_r    <= pos_nxt;
      sub_r    <= sub_nxt;
      stamp_r  <= stamp_nxt;
      length_r <= length_nxt;
      count_r  <= count_nxt;
      last_r   <= last_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // payload count stays below the header length while payload runs
  a_count_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> 32'(count_r) < length_r)
    else $error("payload count reached header length inside payload");

  // multi-byte header fields never index past byte three
  a_field_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_STAMP || phase_r == PH_LEN) |-> pos_r[2] == 1'b0)
    else $error("header byte position out of range");

  // a good frame is always followed by the expect-tag phase
  a_ok_then_expect: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && res_valid && res.out_type == tfd_pkg::TYPE_OK |=> phase_r == PH_EXPECT)
    else $error("frame completion not followed by tag expectation");

  // hunting never reports anything
  a_hunt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && phase_r == PH_HUNT |-> !res_valid)
    else $error("result produced while hunting");
`endif

endmodule

FILE: hw/rtl/tagged_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// tagged_frame_deframer_top: byte-serial tagged frame receiver
// Parses tag, header, payload and trailer; emits payload bytes and one
// completion or error word per frame.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | content
//  in_     | in  | in_tvalid/tready    | tdata[7:0] rx_byte
//  out_    | out | out_tvalid/tready   | tuser out_type, tdata header + byte
//  cfg_    | in  | cfg_we              | cfg_wdata max_payload
//
// One byte per cycle unless output stalls: each word is parsed in one pass by
// the state machine; its result lands in one output register the next cycle.
// A byte is taken whenever the output register is empty or drains this cycle.
// Reset (rst_n low, synchronous) returns to tag hunting, max_payload 65535.
// A stalled output holds its word and blocks input only while it stays full.
// ----------------------------------------------------------------------------
module tagged_frame_deframer_top #(
  parameter int LEN_BITS = tfd_pkg::LEN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // rx_byte [7:0]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // frame_kind [1:0], data_byte [9:2], sub_type [17:10], time_stamp [49:18],
  // payload_len [65:50], error_code [68:66], zero [71:69]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,
  // out_type [1:0]
  output logic [1:0]  out_tuser,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic             in_accept;
  logic [15:0]      max_payload_r;
  logic             res_valid;
  tfd_pkg::result_t res;
  logic             out_valid_r, out_valid_nxt;
  tfd_pkg::result_t out_res_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  // Hold the length limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= tfd_pkg::MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      max_payload_r <= cfg_wdata;
    end
  end

  tfd_parser #(
    .LEN_BITS (LEN_BITS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_accept   (in_accept),
    .rx_byte     (in_tdata),
    .max_payload (max_payload_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Load a new result or drain the output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.out_type;
  assign out_tdata  = {3'b000, out_res_r.error_code, out_res_r.payload_len,
                       out_res_r.time_stamp, out_res_r.sub_type,
                       out_res_r.data_byte, out_res_r.frame_kind};

endmodule

FILE: tb/tagged_frame_deframer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_frame_deframer_top_test: self-checking bench for the frame deframer
// Feeds tagged frames one byte per word: clean frames, corrupted, truncated
// and over-long ones, and line noise. The receive side stalls at random.
// A scoreboard tracks the parser state, predicts every result word and
// checks each word as it leaves. max_payload steps through several values,
// both extremes included.
// ----------------------------------------------------------------------------

// Parser position as the scoreboard sees it
typedef enum logic [3:0] {
  PH_HUNT,
  PH_NEXT_TAG,
  PH_TAG,
  PH_SUBTYPE,
  PH_STAMP,
  PH_LENGTH,
  PH_PAYLOAD,
  PH_TRAILER
} parse_phase_t;

// Letter of a tag name at a position, zero at and past its end
function automatic logic [7:0] tag_letter(input logic [1:0] kind, input int pos);
  string name;
  case (kind)
    tfd_pkg::KIND_STRING: name = "STRING";
    tfd_pkg::KIND_ARRAY:  name = "ARRAY";
    tfd_pkg::KIND_IMAGE:  name = "IMAGE";
    default:              name = "USER";
  endcase
  return (pos < name.len()) ? name[pos] : 8'h00;
endfunction

class frame_scoreboard;
  parse_phase_t      phase;
  logic [1:0]        kind;
  logic [2:0]        pos;
  logic [7:0]        sub;
  logic [31:0]       stamp;
  logic [31:0]       len;
  logic [15:0]       count;
  logic [7:0]        last_byte;
  logic [15:0]       max_len;
  tfd_pkg::result_t  expected[$];
  int                errors;
  int                words_in;
  int                words_out;
  int                payload_words;
  int                ok_frames;
  int                err_by_code[8];

  function new();
    phase   = PH_HUNT;
    kind    = tfd_pkg::KIND_STRING;
    pos     = 3'd0;
    max_len = 16'hFFFF;
    clear_header();
  endfunction

  function void set_max(input logic [15:0] v);
    max_len = v;
  endfunction

  function int pending();
    return expected.size();
  endfunction

  function void clear_header();
    sub       = 8'h00;
    stamp     = 32'h0;
    len       = 32'h0;
    count     = 16'h0;
    last_byte = 8'h00;
  endfunction

  function void start_tag(input logic [1:0] k);
    kind  = k;
    pos   = 3'd1;
    clear_header();
    phase = PH_TAG;
  endfunction

  // Queue one result word built from the current header registers
  function void push(input tfd_pkg::out_type_t t, input logic [7:0] d,
                     input logic [2:0] e);
    tfd_pkg::result_t w;
    w.out_type    = t;
    w.frame_kind  = kind;
    w.data_byte   = d;
    w.sub_type    = sub;
    w.time_stamp  = stamp;
    w.payload_len = (len > 32'hFFFF) ? 16'hFFFF : len[15:0];
    w.error_code  = e;
    expected.push_back(w);
  endfunction

  function void fail(input logic [2:0] e);
    phase = PH_HUNT;
    pos   = 3'd0;
    push(tfd_pkg::TYPE_ERROR, 8'h00, e);
  endfunction

  function bit first_letter(input logic [7:0] b, output logic [1:0] k);
    for (int i = 0; i < 4; i++) begin
      if (tag_letter(2'(i), 0) == b) begin
        k = 2'(i);
        return 1'b1;
      end
    end
    k = tfd_pkg::KIND_STRING;
    return 1'b0;
  endfunction

  // Advance the parser by one accepted byte
  function void note_byte(input logic [7:0] b);
    logic [7:0] want;
    logic [1:0] k;
    words_in++;
    case (phase)
      PH_NEXT_TAG: begin
        if (first_letter(b, k)) begin
          start_tag(k);
        end else begin
          kind = tfd_pkg::KIND_STRING;
          clear_header();
          fail(tfd_pkg::ERR_UNKNOWN_TAG);
        end
      end
      PH_TAG: begin
        want = tag_letter(kind, pos);
        if (b != want) begin
          fail(tfd_pkg::ERR_UNKNOWN_TAG);
        end else if (want != 8'h00) begin
          pos = pos + 3'd1;
        end else if (kind == tfd_pkg::KIND_USER) begin
          phase = PH_NEXT_TAG;
          pos   = 3'd0;
          push(tfd_pkg::TYPE_OK, 8'h00, tfd_pkg::ERR_NONE);
        end else begin
          phase = PH_SUBTYPE;
          pos   = 3'd0;
        end
      end
      PH_SUBTYPE: begin
        sub   = b;
        phase = PH_STAMP;
        pos   = 3'd0;
      end
      PH_STAMP: begin
        stamp[8 * pos[1:0] +: 8] = b;
        pos = pos + 3'd1;
        if (pos == 3'd4) begin
          phase = PH_LENGTH;
          pos   = 3'd0;
        end
      end
      PH_LENGTH: begin
        len[8 * pos[1:0] +: 8] = b;
        pos = pos + 3'd1;
        if (pos == 3'd4) begin
          pos = 3'd0;
          if (len > 32'hFFFF || len > {16'h0, max_len}) begin
            fail(tfd_pkg::ERR_TOO_LONG);
          end else begin
            phase = (len == 32'h0) ? PH_TRAILER : PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        last_byte = b;
        count     = count + 16'd1;
        if ({16'h0, count} >= len) begin
          phase = PH_TRAILER;
          pos   = 3'd0;
        end
        push(tfd_pkg::TYPE_PAYLOAD, b, tfd_pkg::ERR_NONE);
      end
      PH_TRAILER: begin
        want = tag_letter(kind, pos);
        if (b != want) begin
          fail(tfd_pkg::ERR_BAD_TRAILER);
        end else if (want != 8'h00) begin
          pos = pos + 3'd1;
        end else if (kind == tfd_pkg::KIND_STRING &&
                     (len == 32'h0 || last_byte != 8'h00)) begin
          fail(tfd_pkg::ERR_STR_UNTERM);
        end else begin
          phase = PH_NEXT_TAG;
          pos   = 3'd0;
          push(tfd_pkg::TYPE_OK, 8'h00, tfd_pkg::ERR_NONE);
        end
      end
      default: begin
        // Drop anything that is not a tag's first letter
        phase = PH_HUNT;
        if (first_letter(b, k)) start_tag(k);
      end
    endcase
  endfunction

  function void compare_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  // Check one result word against the oldest expectation
  function void check_result(input logic [1:0] tuser, input logic [71:0] tdata);
    tfd_pkg::result_t want;
    if (expected.size() == 0) begin
      errors++;
      $display("%0t: unexpected result word, expected none, actual tuser %0h tdata %0h",
               $time, tuser, tdata);
      return;
    end
    want = expected.pop_front();
    words_out++;
    compare_field("out_type",    want.out_type,    tuser);
    compare_field("frame_kind",  want.frame_kind,  tdata[1:0]);
    compare_field("data_byte",   want.data_byte,   tdata[9:2]);
    compare_field("sub_type",    want.sub_type,    tdata[17:10]);
    compare_field("time_stamp",  want.time_stamp,  tdata[49:18]);
    compare_field("payload_len", want.payload_len, tdata[65:50]);
    compare_field("error_code",  want.error_code,  tdata[68:66]);
    case (want.out_type)
      tfd_pkg::TYPE_PAYLOAD: payload_words++;
      tfd_pkg::TYPE_OK:      ok_frames++;
      default:               err_by_code[want.error_code]++;
    endcase
  endfunction
endclass

module tagged_frame_deframer_top_test;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASE_BYTES  = 290;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  frame_scoreboard sb = new();
  bit          burst;
  bit          hold_req;
  int          cycle_count;
  logic [15:0] random_max;

  tagged_frame_deframer_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Receive side: random ready runs and stalls, plus a long hold on request
  initial begin
    int hold_left;
    int run_left;
    bit run_ready;
    hold_left  = 0;
    run_left   = 0;
    run_ready  = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_ready = !run_ready;
          if (run_ready) run_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 8);
          else run_left = 1 + idle_cycles();
        end
        run_left--;
        out_tready <= run_ready;
      end
    end
  end

  // Offer one byte and hold it until it is taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = burst ? 0 : idle_cycles();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b);
  endtask

  // Stop offering and wait until every expected word is out
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max(input logic [15:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_max(v);
  endtask

  // Build one frame, maybe damage it, and send it
  task automatic send_frame(input bit pressure);
    logic [7:0]  frame_bytes[$];
    logic [1:0]  kind;
    logic [31:0] len;
    logic [31:0] stamp;
    logic [31:0] lim;
    int          r;
    int          p;
    lim   = {16'h0, sb.max_len};
    kind  = 2'($urandom_range(0, 3));
    burst = ($urandom_range(0, 99) < 15);
    r     = $urandom_range(0, 99);
    if (pressure) begin
      kind  = tfd_pkg::KIND_ARRAY;
      burst = 1'b1;
      r     = 50;
      len   = 40;
    end else if (r < 10) len = 0;
    else if (r < 80) len = $urandom_range(1, 12);
    else if (r < 88) len = $urandom_range(13, 300);
    else if (lim == 32'hFFFF || r >= 96) len = $urandom_range(32'h10000, 32'hFFFFFFFF);
    else if (r < 92) len = $urandom_range(lim + 1, 32'hFFFF);
    else len = 32'hFFFF;
    // keep well-formed lengths inside the current limit
    if (r < 88 && len > lim) len = lim;

    for (p = 0; tag_letter(kind, p) != 8'h00; p++) frame_bytes.push_back(tag_letter(kind, p));
    frame_bytes.push_back(8'h00);
    if (kind != tfd_pkg::KIND_USER) begin
      frame_bytes.push_back(8'($urandom_range(0, 255)));
      stamp = $urandom();
      for (p = 0; p < 4; p++) frame_bytes.push_back(stamp[8 * p +: 8]);
      for (p = 0; p < 4; p++) frame_bytes.push_back(len[8 * p +: 8]);
      if (len <= lim) begin
        for (p = 0; p < len; p++) frame_bytes.push_back(8'($urandom_range(0, 255)));
        if (kind == tfd_pkg::KIND_STRING && len != 0 && $urandom_range(0, 9) != 0)
          frame_bytes[frame_bytes.size() - 1] = 8'h00;
        for (p = 0; tag_letter(kind, p) != 8'h00; p++)
          frame_bytes.push_back(tag_letter(kind, p));
        frame_bytes.push_back(8'h00);
      end
    end

    // Damage: flip one byte, cut the frame short, or lead with noise
    if (!pressure) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (r < 17) begin
        frame_bytes = frame_bytes[0 : $urandom_range(0, frame_bytes.size() - 2)];
      end else if (r < 25) begin
        repeat ($urandom_range(1, 4)) frame_bytes.push_front(8'($urandom_range(0, 255)));
      end
    end

    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
  endtask

  task automatic fill_to(input int target);
    while (sb.words_in < target) send_frame(1'b0);
  endtask

  initial begin
    logic [7:0]  directed[$];
    logic [15:0] settings[$];
    int          target;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    cfg_we      = 1'b0;
    cfg_wdata   = 16'h0000;
    burst       = 1'b0;
    hold_req    = 1'b0;
    cycle_count = 0;
    random_max  = 16'($urandom_range(1, 16'hFFFE));
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: user frame, junk after a good frame, dropped noise while
    // hunting, broken tag, extreme header values with zero length and a
    // bad trailer
    directed = '{"U", "S", "E", "R", 8'h00,
                 8'hFF,
                 8'h7F,
                 "I", "X",
                 "S", "T", "R", "I", "N", "G", 8'h00,
                 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                 8'h00, 8'h00, 8'h00, 8'h00,
                 "X"};
    foreach (directed[i]) send_byte(directed[i]);

    // Random frames at the reset limit, then at each written limit
    target = PHASE_BYTES;
    fill_to(target);
    settings = '{16'd0, 16'd7, random_max, 16'd300, 16'hFFFF};
    foreach (settings[i]) begin
      drain();
      write_max(settings[i]);
      if (settings[i] == 16'd300) begin
        // fill the output while the receiver holds off
        hold_req = 1'b1;
        send_frame(1'b1);
      end
      target += PHASE_BYTES;
      fill_to(target);
    end
    drain();
    repeat (10) @(posedge clk);

    $display("Fed %0d bytes over six max_payload settings (65535, 0, 7, %0d, 300, 65535).",
             sb.words_in, random_max);
    $display("Checked %0d words: %0d payload, %0d good frames, errors %0d/%0d/%0d/%0d %s",
             sb.words_out, sb.payload_words, sb.ok_frames,
             sb.err_by_code[tfd_pkg::ERR_UNKNOWN_TAG],
             sb.err_by_code[tfd_pkg::ERR_BAD_TRAILER],
             sb.err_by_code[tfd_pkg::ERR_STR_UNTERM],
             sb.err_by_code[tfd_pkg::ERR_TOO_LONG],
             "(tag/trailer/unterminated/too long)");
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
